// ===== sv/grs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grs_pkg: shared types and constants for the group reverse stream
// Sizes of the group buffer, the command queue and the result queue, and the
// structs that travel between the front end and the drain engine.
// ----------------------------------------------------------------------------
package grs_pkg;

   // largest group the buffer holds
   localparam int MAX_GROUP = 16;
   localparam int IDX_W     = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
   localparam int CNT_W     = $clog2(MAX_GROUP + 1);
   // two banks of MAX_GROUP entries (ping-pong)
   localparam int ADDR_W    = IDX_W + 1;

   // command queue between front and back
   localparam int CQ_DEPTH  = 2;
   localparam int CQ_AW     = $clog2(CQ_DEPTH);
   localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);

   // result queue in front of the rsp_ ports
   localparam int OQ_DEPTH  = 4;
   localparam int OQ_AW     = $clog2(OQ_DEPTH);
   localparam int OQ_CNT_W  = $clog2(OQ_DEPTH + 1);

   // buffer write from the front end
   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic signed [31:0] data;
   } wr_type;

   // one group to drain
   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] count;
      logic             reverse;
      logic             eos;
   } cmd_type;

   // drain engine releases a bank
   typedef struct packed {
      logic valid;
      logic bank;
   } done_type;

endpackage

`default_nettype wire

// ===== sv/grs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grs_front: input side of the group reverse stream
// Holds the group size register, writes accepted values into the current
// buffer bank and posts a drain command when a group closes.
// ----------------------------------------------------------------------------
module grs_front import grs_pkg::*; (
   input  wire                 clock,
   input  wire                 reset,
   // configuration
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire  [4:0]          csr_group_size,
   // input transactions
   input  wire                 req_push,
   output logic                req_full,
   input  wire  signed [31:0]  req_value,
   input  wire                 req_end_of_sequence,
   // toward buffer and command queue
   output wr_type              wr,
   output logic                cmd_push,
   output cmd_type             cmd,
   input  wire                 cmd_full,
   input  done_type            done
);

   logic [4:0]        group_size_ff, group_size_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              bank_ff, bank_in;
   logic [1:0]        busy_ff, busy_in;

   logic [CNT_W-1:0]  size_eff;
   logic [CNT_W-1:0]  fill_c;
   logic [CNT_W-1:0]  n_items;
   logic              accept;
   logic              group_full;
   logic              flush;

   assign csr_ready = 1'b1;

   // effective group size: 0 and 1 pass through, large sizes saturate
   always_comb begin
      if (group_size_ff <= 5'd1) begin
         size_eff = CNT_W'(1);
      end else if (int'(group_size_ff) > MAX_GROUP) begin
         size_eff = CNT_W'(MAX_GROUP);
      end else begin
         size_eff = CNT_W'(group_size_ff);
      end
   end

   // classify the incoming transaction
   always_comb begin
      fill_c     = (fill_ff >= CNT_W'(MAX_GROUP)) ? CNT_W'(MAX_GROUP - 1) : fill_ff;
      n_items    = fill_c + CNT_W'(1);
      req_full   = busy_ff[bank_ff] | cmd_full;
      accept     = req_push & ~req_full;
      group_full = n_items >= size_eff;
      flush      = accept & (group_full | req_end_of_sequence);

      wr.en      = accept;
      wr.addr    = {bank_ff, fill_c[IDX_W-1:0]};
      wr.data    = req_value;

      cmd_push    = flush;
      cmd.bank    = bank_ff;
      cmd.count   = n_items;
      cmd.reverse = group_full;
      cmd.eos     = req_end_of_sequence;
   end

   // next state
   always_comb begin
      group_size_in = group_size_ff;
      fill_in       = fill_ff;
      bank_in       = bank_ff;
      busy_in       = busy_ff;
      if (csr_valid && csr_ready) begin
         group_size_in = csr_group_size;
      end
      if (done.valid) begin
         busy_in[done.bank] = 1'b0;
      end
      if (accept) begin
         if (flush) begin
            fill_in          = '0;
            busy_in[bank_ff] = 1'b1;
            bank_in          = ~bank_ff;
         end else begin
            fill_in = n_items;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= 5'd1;
         fill_ff       <= '0;
         bank_ff       <= 1'b0;
         busy_ff       <= '0;
      end else begin
         group_size_ff <= group_size_in;
         fill_ff       <= fill_in;
         bank_ff       <= bank_in;
         busy_ff       <= busy_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/grs_cmd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grs_cmd_queue: drain command queue
// Short FIFO of group commands between the front end and the drain engine.
// ----------------------------------------------------------------------------
module grs_cmd_queue import grs_pkg::*; (
   input  wire       clock,
   input  wire       reset,
   input  wire       push,
   input  cmd_type   push_cmd,
   output logic      full,
   output logic      valid,
   output cmd_type   head,
   input  wire       pop
);

   cmd_type             entry_ff [CQ_DEPTH];
   logic [CQ_AW-1:0]    wp_ff, wp_in;
   logic [CQ_AW-1:0]    rp_ff, rp_in;
   logic [CQ_CNT_W-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   // pointers and occupancy
   always_comb begin
      full     = count_ff == CQ_CNT_W'(CQ_DEPTH);
      valid    = count_ff != '0;
      head     = entry_ff[rp_ff];
      do_push  = push & ~full;
      do_pop   = pop & valid;
      wp_in    = do_push ? ((int'(wp_ff) == CQ_DEPTH - 1) ? '0 : wp_ff + CQ_AW'(1)) : wp_ff;
      rp_in    = do_pop ? ((int'(rp_ff) == CQ_DEPTH - 1) ? '0 : rp_ff + CQ_AW'(1)) : rp_ff;
      count_in = count_ff + CQ_CNT_W'(do_push) - CQ_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff    <= '0;
         rp_ff    <= '0;
         count_ff <= '0;
      end else begin
         wp_ff    <= wp_in;
         rp_ff    <= rp_in;
         count_ff <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wp_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== sv/grs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// grs_back: drain engine of the group reverse stream
// Owns the two-bank group buffer, walks each queued group forward or
// backward through it and feeds a small result queue.
// ----------------------------------------------------------------------------
module grs_back import grs_pkg::*; (
   input  wire                 clock,
   input  wire                 reset,
   input  wr_type              wr,
   input  wire                 cmd_valid,
   input  cmd_type             cmd_head,
   output logic                cmd_pop,
   output done_type            done,
   // result transactions
   output logic                rsp_empty,
   input  wire                 rsp_pop,
   output logic signed [31:0]  rsp_value_res,
   output logic                rsp_end_of_sequence_res
);

   logic signed [31:0]  mem [2*MAX_GROUP];

   logic                active_ff, active_in;
   cmd_type             cur_ff, cur_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic                rd_valid_ff;
   logic signed [31:0]  rd_data_ff;
   logic                rd_eos_ff;

   logic signed [31:0]  oq_val_ff [OQ_DEPTH];
   logic                oq_eos_ff [OQ_DEPTH];
   logic [OQ_AW-1:0]    oq_wp_ff, oq_wp_in;
   logic [OQ_AW-1:0]    oq_rp_ff, oq_rp_in;
   logic [OQ_CNT_W-1:0] oq_count_ff, oq_count_in;

   logic [OQ_CNT_W:0]   oq_claimed;
   logic                rd_issue;
   logic                idx_last;
   logic [CNT_W-1:0]    pos;
   logic [ADDR_W-1:0]   rd_addr;
   logic                oq_pop;

   // read sequencing over the current group
   always_comb begin
      oq_claimed = (OQ_CNT_W + 1)'(oq_count_ff) + (OQ_CNT_W + 1)'(rd_valid_ff);
      cmd_pop    = ~active_ff & cmd_valid;
      rd_issue   = active_ff & (oq_claimed < (OQ_CNT_W + 1)'(OQ_DEPTH));
      idx_last   = idx_ff == (cur_ff.count - CNT_W'(1));
      pos        = cur_ff.reverse ? (cur_ff.count - CNT_W'(1) - idx_ff) : idx_ff;
      rd_addr    = {cur_ff.bank, pos[IDX_W-1:0]};
      done.valid = rd_issue & idx_last;
      done.bank  = cur_ff.bank;

      active_in = active_ff;
      cur_in    = cur_ff;
      idx_in    = idx_ff;
      if (cmd_pop) begin
         active_in = 1'b1;
         cur_in    = cmd_head;
         idx_in    = '0;
      end else if (rd_issue) begin
         idx_in = idx_ff + CNT_W'(1);
         if (idx_last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         idx_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         active_ff   <= active_in;
         idx_ff      <= idx_in;
         rd_valid_ff <= rd_issue;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // group buffer, registered read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_issue) begin
         rd_data_ff <= mem[rd_addr];
         rd_eos_ff  <= idx_last & cur_ff.eos;
      end
   end

   // result queue
   always_comb begin
      rsp_empty               = oq_count_ff == '0;
      rsp_value_res           = oq_val_ff[oq_rp_ff];
      rsp_end_of_sequence_res = oq_eos_ff[oq_rp_ff];
      oq_pop                  = rsp_pop & ~rsp_empty;
      oq_wp_in    = rd_valid_ff ? oq_wp_ff + OQ_AW'(1) : oq_wp_ff;
      oq_rp_in    = oq_pop ? oq_rp_ff + OQ_AW'(1) : oq_rp_ff;
      oq_count_in = oq_count_ff + OQ_CNT_W'(rd_valid_ff) - OQ_CNT_W'(oq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wp_ff    <= '0;
         oq_rp_ff    <= '0;
         oq_count_ff <= '0;
      end else begin
         oq_wp_ff    <= oq_wp_in;
         oq_rp_ff    <= oq_rp_in;
         oq_count_ff <= oq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         oq_val_ff[oq_wp_ff] <= rd_data_ff;
         oq_eos_ff[oq_wp_ff] <= rd_eos_ff;
      end
   end

   // reads in flight never overrun the result queue
   a_oq_bound: assert property (@(posedge clock) disable iff (reset)
      oq_claimed <= (OQ_CNT_W + 1)'(OQ_DEPTH))
      else $error("result queue overrun");

   // a loaded command starts a walk
   a_load_active: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |=> active_ff && idx_ff == '0)
      else $error("command load did not start a drain");

   // walk index stays inside a non-empty group
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (cur_ff.count != '0) && (idx_ff < cur_ff.count))
      else $error("drain index out of group");

endmodule

`default_nettype wire

// ===== sv/group_reverse_stream.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// group_reverse_stream: reverse a value stream in groups of a set size
// Top level: front end, drain command queue and drain engine.
// ----------------------------------------------------------------------------
// Values pushed on req_ are gathered into groups of csr_group_size items
// (0 or 1 passes items through, sizes above 16 act as 16). A full group comes
// out reversed; a partial group closed by req_end_of_sequence comes out in
// arrival order. The end marker of the closing item appears on the last
// result of that group. Within a group the block takes one item per cycle;
// the buffer has two banks, so a new group fills while the previous one
// drains, and req_full rises only while both banks wait to be drained. The
// drain engine reads one buffer entry per cycle through a single read port
// while the result queue has room, and loads each group's command before
// it walks the group. The first result of a group reaches rsp_ through the
// command queue, the registered buffer read and the result queue. Write
// csr_group_size only while the block is idle.
// ----------------------------------------------------------------------------
module group_reverse_stream import grs_pkg::*; (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire  [4:0]          csr_group_size,
   input  wire                 req_push,
   output logic                req_full,
   input  wire  signed [31:0]  req_value,
   input  wire                 req_end_of_sequence,
   output logic                rsp_empty,
   input  wire                 rsp_pop,
   output logic signed [31:0]  rsp_value_res,
   output logic                rsp_end_of_sequence_res
);

   wr_type   wr;
   logic     cmd_push;
   cmd_type  cmd;
   logic     cmd_full;
   logic     cmd_valid;
   cmd_type  cmd_head;
   logic     cmd_pop;
   done_type done;

   grs_front u_front (
      .clock               (clock),
      .reset               (reset),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_group_size      (csr_group_size),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_value           (req_value),
      .req_end_of_sequence (req_end_of_sequence),
      .wr                  (wr),
      .cmd_push            (cmd_push),
      .cmd                 (cmd),
      .cmd_full            (cmd_full),
      .done                (done)
   );

   grs_cmd_queue u_cmd_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (cmd),
      .full     (cmd_full),
      .valid    (cmd_valid),
      .head     (cmd_head),
      .pop      (cmd_pop)
   );

   grs_back u_back (
      .clock                   (clock),
      .reset                   (reset),
      .wr                      (wr),
      .cmd_valid               (cmd_valid),
      .cmd_head                (cmd_head),
      .cmd_pop                 (cmd_pop),
      .done                    (done),
      .rsp_empty               (rsp_empty),
      .rsp_pop                 (rsp_pop),
      .rsp_value_res           (rsp_value_res),
      .rsp_end_of_sequence_res (rsp_end_of_sequence_res)
   );

endmodule

`default_nettype wire

// ===== tb/sv/grs_order_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grs_order_checker: result predictor and scoreboard for group_reverse_stream
// Watches the csr_, req_ and rsp_ channels at the rising clock edge. It keeps
// its own copy of the group size and the group being collected, computes the
// reordered results of each accepted input transaction, and compares every
// popped result field by field against the oldest one still pending.
// ----------------------------------------------------------------------------
module grs_order_checker import grs_pkg::MAX_GROUP; (
   input  wire                clock,
   input  wire                reset,
   input  wire                csr_valid,
   input  wire                csr_ready,
   input  wire         [4:0]  csr_group_size,
   input  wire                req_push,
   input  wire                req_full,
   input  wire  signed [31:0] req_value,
   input  wire                req_end_of_sequence,
   input  wire                rsp_empty,
   input  wire                rsp_pop,
   input  wire  signed [31:0] rsp_value_res,
   input  wire                rsp_end_of_sequence_res,
   output int                 error_count,
   output int                 pending_count
);

   // one reordered result as it should appear on rsp_
   typedef struct packed {
      logic signed [31:0] value;
      logic               eos;
   } ordered_item_type;

   ordered_item_type   expected_results[$];
   logic        [4:0]  size_reg;
   logic signed [31:0] group_store[MAX_GROUP];
   int                 fill;

   initial begin
      error_count   = 0;
      pending_count = 0;
      size_reg      = 5'd1;
      fill          = 0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %h, want %h", $realtime, what, got, want);
      error_count++;
   endtask

   // collect one value; emit the group once it is full or closed by a marker
   task automatic regroup_item(input logic signed [31:0] value, input logic eos);
      int span;
      int held;
      if (size_reg <= 1)
         span = 1;
      else if (size_reg > MAX_GROUP)
         span = MAX_GROUP;
      else
         span = size_reg;
      if (fill >= MAX_GROUP)
         fill = MAX_GROUP - 1;
      group_store[fill] = value;
      fill++;
      held = fill;
      if (held >= span) begin
         // full group (or size lowered below the fill): newest first
         for (int i = 0; i < held; i++)
            expected_results.push_back('{value: group_store[held - 1 - i],
                                         eos: (i == held - 1) ? eos : 1'b0});
         fill = 0;
      end else if (eos) begin
         // partial group closed by the marker: arrival order
         for (int i = 0; i < held; i++)
            expected_results.push_back('{value: group_store[i],
                                         eos: (i == held - 1)});
         fill = 0;
      end
   endtask

   task automatic check_result(input logic signed [31:0] got_value, input logic got_eos);
      ordered_item_type want;
      if (expected_results.size() == 0) begin
         report_mismatch("result with nothing pending", got_value, '0);
         return;
      end
      want = expected_results.pop_front();
      if (got_value !== want.value)
         report_mismatch("value_res", got_value, want.value);
      if (got_eos !== want.eos)
         report_mismatch("end_of_sequence_res", {31'd0, got_eos}, {31'd0, want.eos});
   endtask

   // results leave before the input of the same edge can add any
   always @(posedge clock) begin
      if (reset) begin
         size_reg = 5'd1;
         fill     = 0;
         expected_results.delete();
      end else begin
         if (rsp_pop && !rsp_empty)
            check_result(rsp_value_res, rsp_end_of_sequence_res);
         if (csr_valid && csr_ready)
            size_reg = csr_group_size;
         if (req_push && !req_full)
            regroup_item(req_value, req_end_of_sequence);
      end
      pending_count = expected_results.size();
   end

endmodule

// ===== tb/sv/group_reverse_stream_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// group_reverse_stream_tb: stimulus and verdict for group_reverse_stream
// Drives directed cases (pass-through, marker closing a full and a partial
// group, size lowered while items are held), then random sequences under
// many group sizes with random gaps on both sides, one long receiver hold-off
// that backs the block up, and one stretch without gaps. Checking is done by
// grs_order_checker.
// ----------------------------------------------------------------------------
module group_reverse_stream_tb;

   localparam int DRAIN_CYCLES   = 12;
   localparam int STALL_CYCLES   = 300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int GAP_PERCENT    = 17;

   logic               clock;
   logic               reset;
   logic               csr_valid;
   logic               csr_ready;
   logic        [4:0]  csr_group_size;
   logic               req_push;
   logic               req_full;
   logic signed [31:0] req_value;
   logic               req_end_of_sequence;
   logic               rsp_empty;
   logic               rsp_pop;
   logic signed [31:0] rsp_value_res;
   logic               rsp_end_of_sequence_res;

   int error_count;
   int pending_count;
   int stall_left;
   int quiet_cycles;
   bit stall_request;
   bit sender_quiet;
   bit receiver_quiet;

   group_reverse_stream i_dut (
      .clock                   (clock),
      .reset                   (reset),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_group_size          (csr_group_size),
      .req_push                (req_push),
      .req_full                (req_full),
      .req_value               (req_value),
      .req_end_of_sequence     (req_end_of_sequence),
      .rsp_empty               (rsp_empty),
      .rsp_pop                 (rsp_pop),
      .rsp_value_res           (rsp_value_res),
      .rsp_end_of_sequence_res (rsp_end_of_sequence_res)
   );

   grs_order_checker i_checker (
      .clock                   (clock),
      .reset                   (reset),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_group_size          (csr_group_size),
      .req_push                (req_push),
      .req_full                (req_full),
      .req_value               (req_value),
      .req_end_of_sequence     (req_end_of_sequence),
      .rsp_empty               (rsp_empty),
      .rsp_pop                 (rsp_pop),
      .rsp_value_res           (rsp_value_res),
      .rsp_end_of_sequence_res (rsp_end_of_sequence_res),
      .error_count             (error_count),
      .pending_count           (pending_count)
   );

   // clock
   initial clock = 1'b0;
   always #2 clock = ~clock;

   // value mix: extremes now and then, random otherwise
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return 32'sh0000_0000;
         3: return 32'shFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic bit take_gap();
      return !sender_quiet && ($urandom_range(0, 99) < GAP_PERCENT);
   endfunction

   // one input transaction; push stays high into the next call
   task automatic send_item(input logic signed [31:0] value, input logic eos);
      while (take_gap()) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push            <= 1'b1;
      req_value           <= value;
      req_end_of_sequence <= eos;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
      @(negedge clock);
   endtask

   // stop offering, let every pending result drain, then allow for latency
   task automatic wait_idle();
      req_push <= 1'b0;
      while (pending_count != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_group_size(input logic [4:0] size_value);
      csr_valid      <= 1'b1;
      csr_group_size <= size_value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly well-formed sequences of random length, some stray markers
   task automatic run_phase(input logic [4:0] size_value, input int item_total,
                            input bit hold_rsp);
      int sent;
      int len;
      int span;
      wait_idle();
      write_group_size(size_value);
      if (hold_rsp)
         stall_request = 1'b1;
      span = (size_value <= 1) ? 1 : (size_value > 16) ? 16 : size_value;
      sent = 0;
      while (sent < item_total) begin
         if ($urandom_range(0, 99) < 80) begin
            len = $urandom_range(1, 3 * span);
            for (int i = 0; i < len; i++)
               send_item(pick_value(), i == len - 1);
            sent += len;
         end else begin
            send_item(pick_value(), $urandom_range(0, 3) == 0);
            sent++;
         end
      end
   endtask

   // receiver: random pops, or a long hold-off when requested
   always @(negedge clock) begin
      if (stall_request) begin
         stall_left    = STALL_CYCLES;
         stall_request = 1'b0;
      end
      if (reset)
         rsp_pop <= 1'b0;
      else if (stall_left > 0) begin
         rsp_pop <= 1'b0;
         stall_left--;
      end else
         rsp_pop <= receiver_quiet || ($urandom_range(0, 99) >= GAP_PERCENT);
   end

   // watchdog: cycles without any accepted transaction
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[group_reverse_stream] ERROR");
         $finish;
      end
   end

   // stimulus and verdict
   initial begin
      reset               = 1'b1;
      csr_valid           = 1'b0;
      csr_group_size      = 5'd0;
      req_push            = 1'b0;
      req_value           = '0;
      req_end_of_sequence = 1'b0;
      rsp_pop             = 1'b0;
      stall_left          = 0;
      quiet_cycles        = 0;
      stall_request       = 1'b0;
      sender_quiet        = 1'b0;
      receiver_quiet      = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset size passes items through, extremes and both marker values
      send_item(32'sh7FFF_FFFF, 1'b0);
      send_item(32'sh8000_0000, 1'b1);
      send_item(32'sh0000_0000, 1'b0);
      send_item(32'shFFFF_FFFF, 1'b1);

      // size zero acts as one
      wait_idle();
      write_group_size(5'd0);
      send_item(32'sh5A5A_A5A5, 1'b1);

      // marker completes a full group, then closes a partial one
      wait_idle();
      write_group_size(5'd3);
      send_item(32'sd1, 1'b0);
      send_item(32'sd2, 1'b0);
      send_item(32'sd3, 1'b1);
      send_item(32'sd4, 1'b0);
      send_item(-32'sd5, 1'b1);

      // size lowered below the number of held items
      wait_idle();
      write_group_size(5'd6);
      send_item(32'sd10, 1'b0);
      send_item(32'sd11, 1'b0);
      send_item(32'sd12, 1'b0);
      send_item(32'sd13, 1'b0);
      wait_idle();
      write_group_size(5'd2);
      send_item(32'sd14, 1'b0);

      // random part over many sizes, saturating sizes among them
      run_phase(5'd0, 40, 1'b0);
      run_phase(5'd31, 40, 1'b0);
      run_phase(5'd16, 40, 1'b0);
      sender_quiet = 1'b1;
      run_phase(5'd4, 60, 1'b1);
      receiver_quiet = 1'b1;
      run_phase(5'd7, 40, 1'b0);
      sender_quiet   = 1'b0;
      receiver_quiet = 1'b0;
      run_phase(5'd2, 40, 1'b0);
      run_phase(5'd1, 30, 1'b0);
      run_phase(5'd17, 30, 1'b0);
      repeat (3)
         run_phase(5'($urandom_range(0, 31)), 30, 1'b0);

      wait_idle();
      if (error_count == 0 && pending_count == 0)
         $display("[group_reverse_stream] OK");
      else
         $display("[group_reverse_stream] ERROR");
      $finish;
   end

endmodule
